// ----- design/gbi_pkg.sv -----
// Package for the gravity body integrator: request types, command codes,
// controller/datapath interface structs and fixed-point helpers.
// No dependencies.
package gbi_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DT_FRAC   = 12;
  localparam int ITER      = 32;
  localparam int E0        = 3 * FRAC_BITS - 32;
  localparam int E1        = E0 - 2;
  localparam int NUM_W     = 64 + ((E0 > 0) ? E0 : 0);
  localparam int HI_W      = NUM_W - 32;
  localparam int CMP_W     = (HI_W > 64) ? HI_W : 64;

  typedef enum logic [1:0] {
    CMD_ATTRACT = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NOP     = 2'd3
  } gbi_cmd_t;

  typedef enum logic [2:0] {
    CFG_GRAV_CONST  = 3'd0,
    CFG_BODY_RADIUS = 3'd1,
    CFG_INIT_POS_X  = 3'd2,
    CFG_INIT_POS_Y  = 3'd3,
    CFG_INIT_VEL_X  = 3'd4,
    CFG_INIT_VEL_Y  = 3'd5
  } gbi_cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        src_mass;
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic [30:0]        src_radius;
    logic [15:0]        time_step;
  } gbi_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               colliding;
    logic               saturated;
  } gbi_out_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_SQ_AX, OP_SQ_BY, OP_SQ_R, OP_COLL, OP_SQ_SB, OP_SQ_SUM,
    OP_SQRT, OP_DEN, OP_GM, OP_DIVQ_INIT, OP_DIV, OP_QSAVE, OP_UX, OP_UY, OP_ACCY,
    OP_T1, OP_T2, OP_T3, OP_T4, OP_T5, OP_RESTART
  } gbi_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_SQ_AX, ST_SQ_BY, ST_SQ_R, ST_COLL, ST_SQ_SB, ST_SQ_SUM,
    ST_SQRT, ST_DEN, ST_GM, ST_DIVQ_INIT, ST_DIVQ, ST_QSAVE, ST_DIVX, ST_UX,
    ST_DIVY, ST_UY, ST_ACCY, ST_T1, ST_T2, ST_T3, ST_T4, ST_T5, ST_RESTART, ST_DONE
  } gbi_state_t;

  typedef struct packed {
    gbi_op_t op;
    logic    ready;
    logic    done;
  } gbi_ctl_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       zero_dist;
  } gbi_stat_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } gbi_sat_t;

  function automatic gbi_sat_t sat_add(logic signed [31:0] a, logic signed [55:0] b);
    logic signed [56:0] sum;
    gbi_sat_t           res;
    sum = 57'(a) + 57'(b);
    if (sum > 57'sd2147483647) begin
      res.val  = 32'sh7fffffff;
      res.clip = 1'b1;
    end else if (sum < -57'sd2147483648) begin
      res.val  = 32'sh80000000;
      res.clip = 1'b1;
    end else begin
      res.val  = sum[31:0];
      res.clip = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [NUM_W-1:0] scale_gm(logic [63:0] gm, int e);
    if (e >= 0) begin
      return NUM_W'(gm) << e;
    end else begin
      return NUM_W'(gm >> (-e));
    end
  endfunction

endpackage

// ----- design/gbi_ctrl.sv -----
// Controller state machine of the gravity body integrator.
// Sequences the datapath operations; depends on gbi_pkg.
module gbi_ctrl import gbi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_free,
  input  gbi_stat_t stat,
  output gbi_ctl_t  ctl
);

  gbi_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       last;

  assign last = (cnt_r == 5'(ITER - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.op    = OP_IDLE;
    ctl.ready = 1'b0;
    ctl.done  = 1'b0;
    cnt_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.ready = 1'b1;
        if (in_valid) begin
          ctl.op    = OP_LOAD;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat.cmd)
          CMD_ATTRACT: state_nxt = ST_SQ_AX;
          CMD_TICK:    state_nxt = ST_T1;
          CMD_RESTART: state_nxt = ST_RESTART;
          default:     state_nxt = ST_DONE;
        endcase
      end
      ST_SQ_AX: begin ctl.op = OP_SQ_AX; state_nxt = ST_SQ_BY; end
      ST_SQ_BY: begin ctl.op = OP_SQ_BY; state_nxt = ST_SQ_R; end
      ST_SQ_R:  begin ctl.op = OP_SQ_R;  state_nxt = ST_COLL; end
      ST_COLL: begin
        ctl.op    = OP_COLL;
        state_nxt = stat.zero_dist ? ST_DONE : ST_SQ_SB;
      end
      ST_SQ_SB:  begin ctl.op = OP_SQ_SB;  state_nxt = ST_SQ_SUM; end
      ST_SQ_SUM: begin ctl.op = OP_SQ_SUM; state_nxt = ST_SQRT; end
      ST_SQRT: begin
        ctl.op  = OP_SQRT;
        cnt_nxt = cnt_r + 5'd1;
        if (last) state_nxt = ST_DEN;
      end
      ST_DEN:       begin ctl.op = OP_DEN;       state_nxt = ST_GM; end
      ST_GM:        begin ctl.op = OP_GM;        state_nxt = ST_DIVQ_INIT; end
      ST_DIVQ_INIT: begin ctl.op = OP_DIVQ_INIT; state_nxt = ST_DIVQ; end
      ST_DIVQ: begin
        ctl.op  = OP_DIV;
        cnt_nxt = cnt_r + 5'd1;
        if (last) state_nxt = ST_QSAVE;
      end
      ST_QSAVE: begin ctl.op = OP_QSAVE; state_nxt = ST_DIVX; end
      ST_DIVX: begin
        ctl.op  = OP_DIV;
        cnt_nxt = cnt_r + 5'd1;
        if (last) state_nxt = ST_UX;
      end
      ST_UX: begin ctl.op = OP_UX; state_nxt = ST_DIVY; end
      ST_DIVY: begin
        ctl.op  = OP_DIV;
        cnt_nxt = cnt_r + 5'd1;
        if (last) state_nxt = ST_UY;
      end
      ST_UY:      begin ctl.op = OP_UY;      state_nxt = ST_ACCY; end
      ST_ACCY:    begin ctl.op = OP_ACCY;    state_nxt = ST_DONE; end
      ST_T1:      begin ctl.op = OP_T1;      state_nxt = ST_T2; end
      ST_T2:      begin ctl.op = OP_T2;      state_nxt = ST_T3; end
      ST_T3:      begin ctl.op = OP_T3;      state_nxt = ST_T4; end
      ST_T4:      begin ctl.op = OP_T4;      state_nxt = ST_T5; end
      ST_T5:      begin ctl.op = OP_T5;      state_nxt = ST_DONE; end
      ST_RESTART: begin ctl.op = OP_RESTART; state_nxt = ST_DONE; end
      ST_DONE: begin
        ctl.done = 1'b1;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- design/gbi_dpath.sv -----
// Datapath of the gravity body integrator: body state, configuration
// registers, shared multiplier, square-root and divide iterations. Uses gbi_pkg.
module gbi_dpath import gbi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  gbi_ctl_t    ctl,
  input  gbi_in_t     in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  output gbi_stat_t   stat,
  output gbi_out_t    res
);

  logic [31:0]        grav_r, ipx_r, ipy_r, ivx_r, ivy_r;
  logic [30:0]        brad_r;
  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r, acc_x_r, acc_y_r;

  logic [1:0]         cmd_r;
  logic [31:0]        mass_r, q_r;
  logic [30:0]        srad_r;
  logic [15:0]        dt_r;
  logic signed [32:0] d_x_r, d_y_r;
  logic signed [65:0] prod_r;
  logic [63:0]        a2_r, b2_r, sq_r, den_r, dv_r, drem_r;
  logic [32:0]        srem_r, r_r;
  logic [31:0]        res_r, nlo_r, quo_r;
  logic               coll_r, sat_r, s_r, ovf_r;

  logic signed [32:0] d_x_in, d_y_in, ma, mb;
  logic signed [65:0] prod;
  logic [32:0]        abs_x, abs_y;
  logic [31:0]        mag_x, mag_y, rsum, rp, u, ctrm;
  logic               s_now;
  logic [34:0]        srem_sh;
  logic [33:0]        trial;
  logic               sq_ge;
  logic [64:0]        dsh, dsub;
  logic               d_ge;
  logic [NUM_W-1:0]   num;
  logic [HI_W-1:0]    num_hi;
  logic signed [31:0] add_a;
  logic signed [55:0] add_b;
  logic signed [65:0] prod_sh;
  logic signed [33:0] term;
  gbi_sat_t           addv;
  logic               add_en;

  assign d_x_in = 33'(in_data.src_x) - 33'(pos_x_r);
  assign d_y_in = 33'(in_data.src_y) - 33'(pos_y_r);
  assign abs_x  = d_x_r[32] ? 33'(-d_x_r) : 33'(d_x_r);
  assign abs_y  = d_y_r[32] ? 33'(-d_y_r) : 33'(d_y_r);
  assign mag_x  = abs_x[31:0];
  assign mag_y  = abs_y[31:0];
  assign s_now  = mag_x[31] | mag_y[31];
  assign rsum   = {1'b0, brad_r} + {1'b0, srad_r};
  assign rp     = (res_r == '0) ? 32'd1 : res_r;
  assign u      = (ovf_r || quo_r > 32'h80000000) ? 32'h80000000 : quo_r;

  assign srem_sh = {srem_r, sq_r[63:62]};
  assign trial   = {res_r, 2'b01};
  assign sq_ge   = srem_sh >= {1'b0, trial};

  assign dsh  = {drem_r, nlo_r[31]};
  assign dsub = dsh - {1'b0, dv_r};
  assign d_ge = dsh >= {1'b0, dv_r};

  assign num    = s_r ? scale_gm(prod_r[63:0], E1) : scale_gm(prod_r[63:0], E0);
  assign num_hi = num[NUM_W-1:32];

  assign prod    = ma * mb;
  assign prod_sh = prod_r >>> DT_FRAC;
  assign ctrm    = prod_r[62:31];

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (ctl.op)
      OP_SQ_AX: begin ma = {1'b0, mag_x}; mb = {1'b0, mag_x}; end
      OP_SQ_BY: begin ma = {1'b0, mag_y}; mb = {1'b0, mag_y}; end
      OP_SQ_R:  begin ma = {1'b0, rsum};  mb = {1'b0, rsum}; end
      OP_COLL:  begin ma = {1'b0, mag_x >> s_now}; mb = {1'b0, mag_x >> s_now}; end
      OP_SQ_SB: begin ma = {1'b0, mag_y >> s_r}; mb = {1'b0, mag_y >> s_r}; end
      OP_DEN:   begin ma = {1'b0, rp};     mb = {1'b0, rp}; end
      OP_GM:    begin ma = {1'b0, grav_r}; mb = {1'b0, mass_r}; end
      OP_UX, OP_UY: begin ma = {1'b0, q_r}; mb = {1'b0, u}; end
      OP_T1:    begin ma = 33'(acc_x_r); mb = {17'b0, dt_r}; end
      OP_T2:    begin ma = 33'(acc_y_r); mb = {17'b0, dt_r}; end
      OP_T3:    begin ma = 33'(vel_x_r); mb = {17'b0, dt_r}; end
      OP_T4:    begin ma = 33'(vel_y_r); mb = {17'b0, dt_r}; end
      default: ;
    endcase
  end

  always_comb begin
    term   = ((ctl.op == OP_UY) ? d_x_r[32] : d_y_r[32]) ? -34'(ctrm) : 34'(ctrm);
    add_a  = '0;
    add_b  = '0;
    add_en = 1'b1;
    unique case (ctl.op)
      OP_T2:   begin add_a = vel_x_r; add_b = prod_sh[55:0]; end
      OP_T3:   begin add_a = vel_y_r; add_b = prod_sh[55:0]; end
      OP_T4:   begin add_a = pos_x_r; add_b = prod_sh[55:0]; end
      OP_T5:   begin add_a = pos_y_r; add_b = prod_sh[55:0]; end
      OP_UY:   begin add_a = acc_x_r; add_b = 56'(term); end
      OP_ACCY: begin add_a = acc_y_r; add_b = 56'(term); end
      default: add_en = 1'b0;
    endcase
    addv = sat_add(add_a, add_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r  <= 32'd16777216;
      brad_r  <= 31'd65536;
      ipx_r   <= '0;
      ipy_r   <= '0;
      ivx_r   <= '0;
      ivy_r   <= '0;
      pos_x_r <= '0;
      pos_y_r <= '0;
      vel_x_r <= '0;
      vel_y_r <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_GRAV_CONST:  grav_r <= cfg_wdata;
          CFG_BODY_RADIUS: brad_r <= cfg_wdata[30:0];
          CFG_INIT_POS_X:  ipx_r  <= cfg_wdata;
          CFG_INIT_POS_Y:  ipy_r  <= cfg_wdata;
          CFG_INIT_VEL_X:  ivx_r  <= cfg_wdata;
          CFG_INIT_VEL_Y:  ivy_r  <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (ctl.op)
        OP_T2:   vel_x_r <= addv.val;
        OP_T3:   vel_y_r <= addv.val;
        OP_T4:   pos_x_r <= addv.val;
        OP_T5: begin
          pos_y_r <= addv.val;
          acc_x_r <= '0;
          acc_y_r <= '0;
        end
        OP_UY:   acc_x_r <= addv.val;
        OP_ACCY: acc_y_r <= addv.val;
        OP_RESTART: begin
          pos_x_r <= ipx_r;
          pos_y_r <= ipy_r;
          vel_x_r <= ivx_r;
          vel_y_r <= ivy_r;
          acc_x_r <= '0;
          acc_y_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (add_en) sat_r <= sat_r | addv.clip;
    unique case (ctl.op)
      OP_LOAD: begin
        cmd_r  <= in_data.cmd;
        mass_r <= in_data.src_mass;
        srad_r <= in_data.src_radius;
        dt_r   <= in_data.time_step;
        d_x_r  <= d_x_in;
        d_y_r  <= d_y_in;
        coll_r <= 1'b0;
        sat_r  <= 1'b0;
      end
      OP_SQ_AX: prod_r <= prod;
      OP_SQ_BY: begin a2_r <= prod_r[63:0]; prod_r <= prod; end
      OP_SQ_R:  begin b2_r <= prod_r[63:0]; prod_r <= prod; end
      OP_COLL: begin
        coll_r <= (65'(a2_r) + 65'(b2_r)) <= 65'(prod_r[63:0]);
        s_r    <= s_now;
        prod_r <= prod;
      end
      OP_SQ_SB: begin sq_r <= prod_r[63:0]; prod_r <= prod; end
      OP_SQ_SUM: begin
        sq_r   <= sq_r + prod_r[63:0];
        srem_r <= '0;
        res_r  <= '0;
      end
      OP_SQRT: begin
        srem_r <= sq_ge ? 33'(srem_sh - {1'b0, trial}) : srem_sh[32:0];
        res_r  <= {res_r[30:0], sq_ge};
        sq_r   <= {sq_r[61:0], 2'b00};
      end
      OP_DEN: begin
        r_r    <= {1'b0, rp} << s_r;
        prod_r <= prod;
      end
      OP_GM: begin den_r <= prod_r[63:0]; prod_r <= prod; end
      OP_DIVQ_INIT: begin
        ovf_r  <= CMP_W'(num_hi) >= CMP_W'(den_r);
        drem_r <= 64'(num_hi);
        nlo_r  <= num[31:0];
        dv_r   <= den_r;
        quo_r  <= '0;
      end
      OP_DIV: begin
        drem_r <= d_ge ? dsub[63:0] : dsh[63:0];
        nlo_r  <= {nlo_r[30:0], 1'b0};
        quo_r  <= {quo_r[30:0], d_ge};
      end
      OP_QSAVE: begin
        q_r    <= ovf_r ? '1 : quo_r;
        sat_r  <= sat_r | ovf_r;
        ovf_r  <= {2'b0, mag_x[31:1]} >= r_r;
        drem_r <= {33'b0, mag_x[31:1]};
        nlo_r  <= {mag_x[0], 31'b0};
        dv_r   <= {31'b0, r_r};
        quo_r  <= '0;
      end
      OP_UX: begin
        prod_r <= prod;
        ovf_r  <= {2'b0, mag_y[31:1]} >= r_r;
        drem_r <= {33'b0, mag_y[31:1]};
        nlo_r  <= {mag_y[0], 31'b0};
        quo_r  <= '0;
      end
      OP_UY, OP_T1, OP_T2, OP_T3, OP_T4: prod_r <= prod;
      default: ;
    endcase
  end

  assign stat.cmd       = cmd_r;
  assign stat.zero_dist = (d_x_r == '0) && (d_y_r == '0);

  assign res.pos_x     = pos_x_r;
  assign res.pos_y     = pos_y_r;
  assign res.vel_x     = vel_x_r;
  assign res.vel_y     = vel_y_r;
  assign res.colliding = coll_r;
  assign res.saturated = sat_r;

endmodule

// ----- design/gravity_body_integrator.sv -----
// Top level of the gravity body integrator: controller, datapath and the
// result register. Depends on gbi_pkg, gbi_ctrl and gbi_dpath.
//
// A request enters on in_valid/in_data when in_stall is low; a result leaves
// on out_valid/out_data when out_stall is low. Every request gives one result
// carrying position and velocity after the request.
// The block takes one request at a time. An attract works through four
// 32-step passes through the square-root iteration and the shared
// restoring divider (force magnitude, then the x and y unit components).
// An attract at zero distance stops after the collision test. A tick runs
// five steps of products on the shared multiplier and saturating adds. The
// next request is accepted in the cycle after the result is loaded.
// A finished result waits in the output register; while out_stall holds it
// there, the next request is accepted and worked on, and its result waits
// until the register is free.
// Configuration writes on cfg_we/cfg_idx/cfg_wdata are meant for idle time.
// Synchronous reset clears the body state to zero, loads the register reset
// values and empties the output register.
module gravity_body_integrator import gbi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  gbi_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output gbi_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  gbi_ctl_t  ctl;
  gbi_stat_t stat;
  gbi_out_t  res;
  gbi_out_t  out_data_r;
  logic      out_valid_r;
  logic      out_free;

  assign out_free = !out_valid_r || !out_stall;

  gbi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl)
  );

  gbi_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.done && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done && out_free) out_data_r <= res;
  end

  assign in_stall  = !ctl.ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/gbi_checker.sv -----
// Port-level checks for the gravity body integrator, bound to the top level.
// Depends on gbi_pkg and gravity_body_integrator.
module gbi_checker import gbi_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input gbi_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Second request taken while busy.");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared without a request in progress.");

endmodule

bind gravity_body_integrator gbi_checker u_gbi_checker (.*);
